// ----- rtl/meo_pkg.sv -----
// ----------------------------------------------------------------------------
// Mecanum encoder odometry package
// Constants, register indexes, sequencer states and the control and status
// structures shared by the odometry core and its arithmetic datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package meo_pkg;

  // 2*pi held as Q4.28.
  localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
  // Scale from seconds to microseconds and from radians to microradians.
  localparam logic [31:0] MICRO      = 32'd1000000;

  localparam logic [19:0] RADIUS_RST     = 20'd30000;
  localparam logic [23:0] HALF_TRACK_RST = 24'd100000;
  localparam logic [15:0] TICKS_RST      = 16'd1440;

  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Number of quotient bits produced by the divider.
  localparam int unsigned QUOT_BITS = 32;

  typedef enum logic [1:0] {
    CFG_WHEEL_RADIUS = 2'd0,
    CFG_HALF_TRACK   = 2'd1,
    CFG_TICKS        = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    OUT_VEL_FWD     = 3'd0,
    OUT_VEL_STRAFE  = 3'd1,
    OUT_TURN        = 3'd2,
    OUT_DIST_FWD    = 3'd3,
    OUT_DIST_STRAFE = 3'd4
  } out_sel_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_MUL,
    DP_DIV_INIT,
    DP_DIV_STEP
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN_LOAD,
    ST_DEN_MUL,
    ST_DEN_CAP,
    ST_SUM,
    ST_LOAD,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_RESULT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    dp_cmd_t     cmd;
    logic        first;
    logic [31:0] mult;
    logic [33:0] load_val;
    logic [59:0] den;
  } dp_ctrl_t;

  typedef struct packed {
    logic [59:0] acc_low;
    logic [31:0] quot;
    logic        big;
    logic        zero;
  } dp_stat_t;

endpackage

// ----- rtl/meo_ifs.sv -----
// ----------------------------------------------------------------------------
// Mecanum encoder odometry channels
// Valid/ready channels for encoder samples, odometry results and register
// writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface meo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_front_right;
  logic signed [31:0] pos_front_left;
  logic signed [31:0] pos_rear_left;
  logic signed [31:0] pos_rear_right;
  logic        [19:0] interval_us;
  logic               restart;

  modport source (output valid, pos_front_right, pos_front_left, pos_rear_left,
                  pos_rear_right, interval_us, restart, input ready);
  modport sink   (input valid, pos_front_right, pos_front_left, pos_rear_left,
                  pos_rear_right, interval_us, restart, output ready);
endinterface

interface meo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_forward;
  logic signed [31:0] vel_strafe;
  logic signed [31:0] turn_rate;
  logic signed [31:0] dist_forward;
  logic signed [31:0] dist_strafe;

  modport source (output valid, vel_forward, vel_strafe, turn_rate, dist_forward,
                  dist_strafe, input ready);
  modport sink   (input valid, vel_forward, vel_strafe, turn_rate, dist_forward,
                  dist_strafe, output ready);
endinterface

interface meo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/mecanum_encoder_odometry_core.sv -----
// ----------------------------------------------------------------------------
// Mecanum encoder odometry core
// Forward kinematics of a four-wheel mecanum base from encoder positions:
// body velocities and distance moved since the last restart.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One request on the samples channel is handled at a time. A restart request
// goes straight to the finish state and reaches the result register once
// that register is free, and the next request can be accepted after that.
// Any other request computes the two divisors and then the five results one
// after another before its result is offered, and the next request can be accepted once the core is back in idle.
// The work is done by a single 32x32 multiplier that works through a 128-bit
// product one limb per cycle (up to 4 factors per result, plus the two
// divisors) and by a restoring divider that yields one quotient bit per
// cycle (32 quotient bits for each of the five results). The results sit in an
// output register, so a new sample can be accepted while the previous result
// still waits to be taken. Register writes are taken at any time but should
// only be made while the core is idle.

module mecanum_encoder_odometry_core (
  input logic       clk,
  input logic       rst,
  meo_in_if.sink    samples,
  meo_out_if.source results,
  meo_cfg_if.sink   cfg
);
  import meo_pkg::*;

  // Configuration registers.
  logic [19:0] wheel_radius_um;
  logic [23:0] half_track_um;
  logic [15:0] ticks_per_rev;

  // Position marks kept between samples.
  logic [31:0] last_pos  [4];
  logic [31:0] start_pos [4];
  logic [31:0] pos_in    [4];

  // Working registers for the request in progress.
  logic signed [31:0] dpos [4];
  logic signed [31:0] spos [4];
  logic [19:0]        interval;
  logic signed [34:0] sum;
  logic               neg;
  out_sel_t           out_idx;
  logic [1:0]         pass;
  logic [1:0]         limb;
  logic [4:0]         step;
  logic [35:0]        den_v;
  logic [59:0]        den_t;
  logic [31:0]        res [5];

  logic        out_valid;
  logic [31:0] out_vf, out_vs, out_tr, out_df, out_ds;

  state_t   state, state_next;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  logic        accept;
  logic        out_free;
  logic [1:0]  last_pass;
  logic [31:0] mult_sel;
  logic [59:0] den_sel;
  logic signed [34:0] sum_w;
  logic [33:0] mag_w;
  logic [31:0] res_w;
  logic        over_w;

  assign pos_in[0] = samples.pos_front_right;
  assign pos_in[1] = samples.pos_front_left;
  assign pos_in[2] = samples.pos_rear_left;
  assign pos_in[3] = samples.pos_rear_right;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !out_valid || results.ready;
  assign cfg.ready     = 1'b1;

  // Wheel sums: forward is d1+d2+d3+d4, strafe d1-d2+d3-d4 and turn
  // -d1+d2+d3-d4. Distances use the offsets from the restart marks instead
  // of the deltas from the previous sample.
  function automatic logic signed [34:0] wheel_sum(input out_sel_t sel,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic signed [31:0] c, input logic signed [31:0] d);
    logic signed [34:0] ea, eb, ec, ed;
    logic signed [34:0] r;
    ea = 35'(a);
    eb = 35'(b);
    ec = 35'(c);
    ed = 35'(d);
    case (sel)
      OUT_VEL_FWD, OUT_DIST_FWD:       r = ea + eb + ec + ed;
      OUT_VEL_STRAFE, OUT_DIST_STRAFE: r = ea - eb + ec - ed;
      OUT_TURN:                        r = eb + ec - ea - ed;
      default:                         r = 35'sd0;
    endcase
    return r;
  endfunction

  always_comb begin
    if (out_idx == OUT_DIST_FWD || out_idx == OUT_DIST_STRAFE) begin
      sum_w = wheel_sum(out_idx, spos[0], spos[1], spos[2], spos[3]);
    end else begin
      sum_w = wheel_sum(out_idx, dpos[0], dpos[1], dpos[2], dpos[3]);
    end
  end

  assign mag_w = sum[34] ? 34'(-sum) : sum[33:0];

  // Factors of the numerator: 2*pi, the wheel radius, then one scale of a
  // million for velocities and another for the turn rate.
  always_comb begin
    case (pass)
      2'd0:    mult_sel = TWO_PI_Q28;
      2'd1:    mult_sel = {12'd0, wheel_radius_um};
      default: mult_sel = MICRO;
    endcase
  end

  always_comb begin
    case (out_idx)
      OUT_VEL_FWD, OUT_VEL_STRAFE: last_pass = 2'd2;
      OUT_TURN:                    last_pass = 2'd3;
      default:                     last_pass = 2'd1;
    endcase
  end

  // Divisors: ticks times interval for velocities, that times the half-track
  // for the turn rate, and the tick count alone for distances.
  always_comb begin
    case (out_idx)
      OUT_VEL_FWD, OUT_VEL_STRAFE: den_sel = {24'd0, den_v};
      OUT_TURN:                    den_sel = den_t;
      default:                     den_sel = {44'd0, ticks_per_rev};
    endcase
  end

  // Saturation toward the sign of the sum; a zero dividend gives zero even
  // when the divisor is zero.
  always_comb begin
    over_w = neg ? (stat.quot > SAT_NEG) : (stat.quot > SAT_POS);
    if (stat.zero) begin
      res_w = 32'd0;
    end else if (stat.big || over_w) begin
      res_w = neg ? SAT_NEG : SAT_POS;
    end else begin
      res_w = neg ? 32'(-stat.quot) : stat.quot;
    end
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_next    = state;
    ctrl.cmd      = DP_HOLD;
    ctrl.first    = (limb == 2'd0);
    ctrl.mult     = mult_sel;
    ctrl.load_val = mag_w;
    ctrl.den      = den_sel;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = samples.restart ? ST_FINISH : ST_DEN_LOAD;
        end
      end
      ST_DEN_LOAD: begin
        ctrl.cmd      = DP_LOAD;
        ctrl.load_val = {18'd0, ticks_per_rev};
        state_next    = ST_DEN_MUL;
      end
      ST_DEN_MUL: begin
        ctrl.cmd  = DP_MUL;
        ctrl.mult = (pass == 2'd0) ? {12'd0, interval} : {8'd0, half_track_um};
        if (limb == 2'd3 && pass == 2'd1) begin
          state_next = ST_DEN_CAP;
        end
      end
      ST_DEN_CAP: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.cmd   = DP_LOAD;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctrl.cmd = DP_MUL;
        if (limb == 2'd3 && pass == last_pass) begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        ctrl.cmd   = DP_DIV_INIT;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctrl.cmd = DP_DIV_STEP;
        if (step == 5'(QUOT_BITS - 1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_next = (out_idx == OUT_DIST_STRAFE) ? ST_FINISH : ST_SUM;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  meo_datapath u_datapath (
    .clk  (clk),
    .ctrl (ctrl),
    .stat (stat)
  );

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius_um <= RADIUS_RST;
      half_track_um   <= HALF_TRACK_RST;
      ticks_per_rev   <= TICKS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_index_t'(cfg.index))
        CFG_WHEEL_RADIUS: wheel_radius_um <= cfg.data[19:0];
        CFG_HALF_TRACK:   half_track_um   <= cfg.data;
        CFG_TICKS:        ticks_per_rev   <= cfg.data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Position marks. Deltas wrap modulo 2^32, as the encoders do.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        last_pos[i]  <= 32'd0;
        start_pos[i] <= 32'd0;
      end
    end else if (accept) begin
      for (int i = 0; i < 4; i++) begin
        last_pos[i] <= pos_in[i];
        if (samples.restart) begin
          start_pos[i] <= pos_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        dpos[i] <= pos_in[i] - last_pos[i];
        spos[i] <= pos_in[i] - start_pos[i];
      end
      interval <= samples.interval_us;
    end
  end

  // Counters of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      pass    <= 2'd0;
      limb    <= 2'd0;
      step    <= 5'd0;
      out_idx <= OUT_VEL_FWD;
    end else begin
      case (state)
        ST_DEN_LOAD, ST_LOAD: begin
          pass <= 2'd0;
          limb <= 2'd0;
        end
        ST_DEN_MUL, ST_MUL: begin
          limb <= limb + 2'd1;
          if (limb == 2'd3) begin
            pass <= pass + 2'd1;
          end
        end
        ST_DEN_CAP: begin
          out_idx <= OUT_VEL_FWD;
        end
        ST_DIV_INIT: begin
          step <= 5'd0;
        end
        ST_DIV: begin
          step <= step + 5'd1;
        end
        ST_RESULT: begin
          case (out_idx)
            OUT_VEL_FWD:    out_idx <= OUT_VEL_STRAFE;
            OUT_VEL_STRAFE: out_idx <= OUT_TURN;
            OUT_TURN:       out_idx <= OUT_DIST_FWD;
            default:        out_idx <= OUT_DIST_STRAFE;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Divisor capture, wheel sums and per-result storage.
  always_ff @(posedge clk) begin
    if (state == ST_DEN_MUL && pass == 2'd1 && limb == 2'd0) begin
      den_v <= stat.acc_low[35:0];
    end
    if (state == ST_DEN_CAP) begin
      den_t <= stat.acc_low;
    end
    if (state == ST_SUM) begin
      sum <= sum_w;
    end
    if (state == ST_LOAD) begin
      neg <= sum[34];
    end
    if (accept && samples.restart) begin
      for (int i = 0; i < 5; i++) begin
        res[i] <= 32'd0;
      end
    end else if (state == ST_RESULT) begin
      res[out_idx] <= res_w;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_vf <= res[0];
      out_vs <= res[1];
      out_tr <= res[2];
      out_df <= res[3];
      out_ds <= res[4];
    end
  end

  assign results.valid        = out_valid;
  assign results.vel_forward  = out_vf;
  assign results.vel_strafe   = out_vs;
  assign results.turn_rate    = out_tr;
  assign results.dist_forward = out_df;
  assign results.dist_strafe  = out_ds;

endmodule

// ----- rtl/meo_datapath.sv -----
// ----------------------------------------------------------------------------
// Mecanum encoder odometry datapath
// Shared 32x32 limb multiplier over a 128-bit accumulator and a one bit per
// cycle restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meo_datapath (
  input  logic             clk,
  input  meo_pkg::dp_ctrl_t ctrl,
  output meo_pkg::dp_stat_t stat
);
  import meo_pkg::*;

  logic [127:0] acc;
  logic [31:0]  carry;
  logic [59:0]  rem;
  logic [31:0]  dlo;
  logic [31:0]  quot;
  logic         big;
  logic         zero;

  logic [31:0]  carry_in;
  logic [63:0]  prod;
  logic [65:0]  hi;
  logic         zero_w;
  logic         big_w;
  logic [60:0]  trial;
  logic         ge;

  // The accumulator rotates one limb per cycle, so once all four limbs have
  // passed the product sits in the original limb order.
  assign carry_in = ctrl.first ? 32'd0 : carry;
  assign prod     = {32'd0, acc[31:0]} * {32'd0, ctrl.mult} + {32'd0, carry_in};

  // The Q28 product is shifted down by 30; the top 66 bits of the shifted
  // value decide whether the quotient reaches 2^32.
  assign hi     = acc[127:62];
  assign zero_w = (acc[127:30] == 98'd0);
  assign big_w  = (ctrl.den == 60'd0) ? !zero_w : (hi >= {6'd0, ctrl.den});

  assign trial = {rem, dlo[31]};
  assign ge    = (trial >= {1'b0, ctrl.den});

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      DP_LOAD: begin
        acc <= {94'd0, ctrl.load_val};
      end
      DP_MUL: begin
        acc   <= {prod[31:0], acc[127:32]};
        carry <= prod[63:32];
      end
      DP_DIV_INIT: begin
        rem  <= acc[121:62];
        dlo  <= acc[61:30];
        quot <= 32'd0;
        big  <= big_w;
        zero <= zero_w;
      end
      DP_DIV_STEP: begin
        rem  <= ge ? 60'(trial - {1'b0, ctrl.den}) : trial[59:0];
        quot <= {quot[30:0], ge};
        dlo  <= {dlo[30:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign stat.acc_low = acc[59:0];
  assign stat.quot    = quot;
  assign stat.big     = big;
  assign stat.zero    = zero;

endmodule

// ----- rtl/meo_checker.sv -----
// ----------------------------------------------------------------------------
// Mecanum encoder odometry checker
// Port-level assertions on the odometry core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] vel_forward,
  input logic [31:0] vel_strafe,
  input logic [31:0] turn_rate,
  input logic [31:0] dist_forward,
  input logic [31:0] dist_strafe
);

  // One request at a time: the core is busy straight after taking one.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a second request while busy");

  // A restart request with a free result register passes through the finish
  // state into the result register, which then offers all zeros.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_restart && !out_valid |=> ##1
      out_valid && vel_forward == 32'd0 && vel_strafe == 32'd0 &&
      turn_rate == 32'd0 && dist_forward == 32'd0 && dist_strafe == 32'd0)
    else $error("restart did not give a zero result");

  // A result that is not taken stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable(vel_forward) && $stable(vel_strafe) && $stable(turn_rate) &&
      $stable(dist_forward) && $stable(dist_strafe))
    else $error("stalled result changed or vanished");

  // Reset leaves no result offered.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind mecanum_encoder_odometry_core meo_checker u_meo_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .in_restart   (samples.restart),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .vel_forward  (results.vel_forward),
  .vel_strafe   (results.vel_strafe),
  .turn_rate    (results.turn_rate),
  .dist_forward (results.dist_forward),
  .dist_strafe  (results.dist_strafe)
);
